/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/pwbh_pkg.sv */
// ---------------------------------------------------------------------------
// Position weighted byte hash package
// Constants, sequencer states and the truncating remainder helper.
// ---------------------------------------------------------------------------
package pwbh_pkg;

	localparam logic [31:0] MulX     = 32'd85432100;
	localparam logic [31:0] MulRound = 32'd100000001;
	localparam int unsigned ModStart = 512;
	localparam int unsigned NumTerms = 9;
	localparam int unsigned CntW     = $clog2(NumTerms);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_MUL_X   = 6'b000010,
		ST_MUL_POS = 6'b000100,
		ST_REM     = 6'b001000,
		ST_MUL_RND = 6'b010000,
		ST_FIN     = 6'b100000
	} state_t;

	// Remainder truncated toward zero by a power of two given as its mask.
	function automatic logic [31:0] trunc_rem(input logic [31:0] v, input logic [31:0] mask);
		logic [31:0] mag;
		begin
			mag = 32'd0 - v;
			if (v[31]) begin
				trunc_rem = 32'd0 - (mag & mask);
			end else begin
				trunc_rem = v & mask;
			end
		end
	endfunction

endpackage

/* hw/rtl/position_weighted_byte_hash.sv */
// ---------------------------------------------------------------------------
// Position weighted byte hash
// Hashes a password one byte per transfer with a single shared multiplier.
// ---------------------------------------------------------------------------
// Input channel: data_byte and last, with in_valid / in_ready. Each byte is
// taken as a signed value and weighted by its 1-based position in the password.
// Output channel: hash_value with out_valid / out_ready, one transfer for each
// byte marked last.
// One byte keeps the block busy after its input transfer, so a new byte is
// taken only once the sequencer is back in idle. The busy time is set by one
// 32x32 multiplier used for three products per byte plus nine remainder terms
// that pass through one adder, one term per cycle.
// The result is available on the cycle after the sequencer finishes a last
// byte. It sits in an output register, so the next password may begin while
// the result waits. If the receiver stalls and a second result is ready, the
// sequencer holds in its final step until the output register is free.
// Reset clears the running hash, the byte position and the output valid.
// ---------------------------------------------------------------------------
module position_weighted_byte_hash
	import pwbh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] hash_value
);

	state_t            state_q;
	logic [7:0]        data_q;
	logic              last_q;
	logic [31:0]       prod_q;
	logic [31:0]       pos_q;
	logic [31:0]       hash_q;
	logic [CntW-1:0]   cnt_q;
	logic              out_valid_q;
	logic [31:0]       out_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;
	logic [31:0] term;
	logic [31:0] rem_mask;
	logic        out_free;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign hash_value = out_q;
	assign out_free   = !out_valid_q || out_ready;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = hash_q;
		mul_b = MulRound;
		case (state_q)
			ST_MUL_X: begin
				mul_a = {{24{data_q[7]}}, data_q};
				mul_b = MulX;
			end
			ST_MUL_POS: begin
				mul_a = prod_q;
				mul_b = pos_q;
			end
			default: begin
				mul_a = hash_q;
				mul_b = MulRound;
			end
		endcase
	end

	assign mul_p = 32'(mul_a * mul_b);

	// Odd terms use the negated product; the modulus halves every term.
	assign rem_mask = 32'(ModStart - 1) >> cnt_q;
	assign term     = trunc_rem(cnt_q[0] ? (32'd0 - prod_q) : prod_q, rem_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			hash_q      <= '0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q   <= pos_q + 32'd1;
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					state_q <= ST_MUL_POS;
				end
				ST_MUL_POS: begin
					cnt_q   <= '0;
					state_q <= ST_REM;
				end
				ST_REM: begin
					hash_q <= hash_q + term;
					cnt_q  <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(NumTerms - 1)) begin
						state_q <= ST_MUL_RND;
					end
				end
				ST_MUL_RND: begin
					hash_q  <= mul_p;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						hash_q      <= '0;
						pos_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output valid: set when a finished hash is loaded, cleared on its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && last_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_byte;
			last_q <= last;
		end
		if (state_q == ST_MUL_X || state_q == ST_MUL_POS) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_FIN && last_q && out_free) begin
			out_q <= hash_q;
		end
	end

endmodule

/* hw/rtl/pwbh_checker.sv */
// ---------------------------------------------------------------------------
// Position weighted byte hash checker
// Port-level assertions on the hash block, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pwbh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] hash_value
);

	// A stalled result holds its value.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hash_value))

	// The block is busy after taking a byte.
	`ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready ##1 !in_ready)

	// A new result only appears at the end of a byte's processing.
	`ASSERT_SAME(a_out_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind position_weighted_byte_hash pwbh_checker u_pwbh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hash_value(hash_value)
);

/* bench/hash_checker.sv */
// ---------------------------------------------------------------------------
// Position weighted byte hash checker
// Watches both channels, predicts the hash of every password from the
// accepted bytes and compares each output transfer with the oldest expected
// hash. Failures are counted and reported to the testbench top.
// ---------------------------------------------------------------------------
module hash_checker
	import pwbh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] hash_value,
	output int                 fail_count,
	output int                 pending
);

	logic [31:0]        hash_acc;
	logic [31:0]        byte_pos;
	logic [31:0]        next_pos;
	logic signed [31:0] want_hash;
	logic signed [31:0] expected_hashes[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Signed modulo truncates toward zero, so the remainder keeps the sign
	// of the dividend, and the most negative value leaves zero.
	function automatic logic [31:0] signed_rem(input logic [31:0] v, input int unsigned m);
		int dividend;
		dividend = v;
		return dividend % int'(m);
	endfunction

	function automatic logic [31:0] mix_byte(input logic [31:0] acc, input logic [31:0] pos,
			input logic [7:0] b);
		logic [31:0] weighted;
		logic [31:0] sum;
		int unsigned modulus;
		bit          flip;
		weighted = {{24{b[7]}}, b} * MulX * pos;
		sum = acc;
		modulus = ModStart;
		flip = 1'b0;
		for (int i = 0; i < NumTerms; i++) begin
			sum = sum + signed_rem(flip ? (32'd0 - weighted) : weighted, modulus);
			modulus = modulus >> 1;
			flip = !flip;
		end
		return sum * MulRound;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_acc <= 32'd0;
			byte_pos <= 32'd0;
			expected_hashes.delete();
			pending <= 0;
		end else begin
			// An output transfer at this edge can never belong to a byte taken
			// at the same edge, so it is checked first.
			if (out_valid && out_ready) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: unexpected hash_value transfer, expected none, actual %0d",
						$time, hash_value);
					fail_count <= fail_count + 1;
				end else begin
					want_hash = expected_hashes.pop_front();
					if (hash_value !== want_hash) begin
						$display("%0t: hash_value mismatch, expected %0d, actual %0d",
							$time, want_hash, hash_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				next_pos = byte_pos + 32'd1;
				if (last) begin
					expected_hashes.push_back(mix_byte(hash_acc, next_pos, data_byte));
					hash_acc <= 32'd0;
					byte_pos <= 32'd0;
				end else begin
					hash_acc <= mix_byte(hash_acc, next_pos, data_byte);
					byte_pos <= next_pos;
				end
			end
			pending <= expected_hashes.size();
		end
	end

endmodule

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// Position weighted byte hash testbench
// Sends directed and random passwords through the input channel with random
// gaps and output stalls; a separate checker predicts and compares hashes.
// ---------------------------------------------------------------------------
module tb;

	localparam int ByteTarget = 1500;
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 30;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               last;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] hash_value;
	int                 fail_count;
	int                 pending;
	int                 bytes_sent;
	int                 cycle_count;
	logic               calm;

	position_weighted_byte_hash uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	hash_checker hash_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// A stretch of the run goes without any idling on either side.
	assign calm = (bytes_sent >= 700) && (bytes_sent < 1000);

	always @(negedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
	end

	// Presents one byte and holds it until the transfer happens.
	task automatic push_byte(input logic [7:0] b, input logic is_last);
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent = bytes_sent + 1;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] corner[5];
		corner = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'h01};
		if ($urandom_range(3) == 0) begin
			return corner[$urandom_range(4)];
		end
		return 8'($urandom_range(255));
	endfunction

	initial begin
		logic [7:0] mixed[7];
		int         len;
		mixed = '{8'h7f, 8'hff, 8'h00, 8'h80, 8'h01, 8'h55, 8'haa};
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last = 1'b0;
		out_ready = 1'b0;
		bytes_sent = 0;
		cycle_count = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-byte passwords at the extremes of a signed byte and around zero.
		push_byte(8'h00, 1'b1);
		push_byte(8'h7f, 1'b1);
		push_byte(8'h80, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte(8'h01, 1'b1);
		// Repeated most negative byte, so the position weight grows.
		for (int i = 0; i < 5; i++) begin
			push_byte(8'h80, i == 4);
		end
		for (int i = 0; i < 7; i++) begin
			push_byte(mixed[i], i == 6);
		end
		// All-zero password of several bytes.
		for (int i = 0; i < 3; i++) begin
			push_byte(8'h00, i == 2);
		end

		while (bytes_sent < ByteTarget) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
			for (int i = 0; i < len; i++) begin
				push_byte(pick_byte(), i == len - 1);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
